// ===== rtl/mswd_pkg.sv =====
`timescale 1ns / 1ps

package mswd_pkg;

  // Table geometry.
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  // Field widths of the item channels.
  localparam int TAG_W      = 64;
  localparam int SLOT_NUM_W = 7;
  localparam int TIME_W     = 32;
  localparam int RSLOT_W    = 8;
  localparam int ECOUNT_W   = 9;

  // Configuration port.
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    CMD_REGISTER    = 2'd0,
    CMD_SET_TIMEOUT = 2'd1,
    CMD_FEED        = 2'd2,
    CMD_CHECK       = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_RANGE     = 2'd2,
    ST_UNREG     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_ENABLED     = 2'd0,
    REG_MIN_TIMEOUT = 2'd1,
    REG_DEF_TIMEOUT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              enabled;
    logic [TIME_W-1:0] minimum_timeout;
    logic [TIME_W-1:0] default_timeout;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan_read;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic needs_scan;
    logic last_addr;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/mswd_if.sv =====
`timescale 1ns / 1ps

interface mswd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [63:0] name_tag;
  logic [6:0]  slot_number;
  logic [31:0] timeout_seconds;
  logic [31:0] now_seconds;

  modport source (output valid, command, name_tag, slot_number, timeout_seconds,
                  now_seconds, input ready);
  modport sink   (input valid, command, name_tag, slot_number, timeout_seconds,
                  now_seconds, output ready);
endinterface

interface mswd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] result_slot;
  logic       any_expired;
  logic [8:0] expired_count;
  logic [7:0] first_expired;

  modport source (output valid, status, result_slot, any_expired, expired_count,
                  first_expired, input ready);
  modport sink   (input valid, status, result_slot, any_expired, expired_count,
                  first_expired, output ready);
endinterface

// ===== rtl/mswd_regs.sv =====
`timescale 1ns / 1ps

module mswd_regs import mswd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output cfg_t               cfg
);

  logic              enabled_r;
  logic [TIME_W-1:0] min_r;
  logic [TIME_W-1:0] def_r;
  reg_idx_e          idx;
  logic              wr_en;

  assign idx   = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b1;
      min_r     <= TIME_W'(1);
      def_r     <= TIME_W'(60);
    end else if (wr_en) begin
      unique case (idx)
        REG_ENABLED:     enabled_r <= pwdata[0];
        REG_MIN_TIMEOUT: min_r     <= pwdata[TIME_W-1:0];
        REG_DEF_TIMEOUT: def_r     <= pwdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ENABLED:     prdata = PDATA_W'(enabled_r);
      REG_MIN_TIMEOUT: prdata = PDATA_W'(min_r);
      REG_DEF_TIMEOUT: prdata = PDATA_W'(def_r);
      default:         prdata = '0;
    endcase
  end

  assign cfg = '{enabled: enabled_r, minimum_timeout: min_r, default_timeout: def_r};

endmodule

// ===== rtl/mswd_ctrl.sv =====
`timescale 1ns / 1ps

module mswd_ctrl import mswd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: state_nxt = stat.needs_scan ? S_SCAN : S_FINISH;
      S_SCAN:     if (stat.last_addr) state_nxt = S_DRAIN;
      S_DRAIN:    state_nxt = S_FINISH;
      S_FINISH:   if (stat.out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.load      = 1'b0;
    cmd.scan_read = 1'b0;
    cmd.commit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN:   cmd.scan_read = 1'b1;
      S_FINISH: cmd.commit = stat.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/mswd_dp.sv =====
`timescale 1ns / 1ps

module mswd_dp import mswd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  input  cfg_t                  cfg,
  input  logic [1:0]            in_command,
  input  logic [TAG_W-1:0]      in_name_tag,
  input  logic [SLOT_NUM_W-1:0] in_slot_number,
  input  logic [TIME_W-1:0]     in_timeout_seconds,
  input  logic [TIME_W-1:0]     in_now_seconds,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [RSLOT_W-1:0]    out_result_slot,
  output logic                  out_any_expired,
  output logic [ECOUNT_W-1:0]   out_expired_count,
  output logic [RSLOT_W-1:0]    out_first_expired
);

  // Latched item.
  cmd_e                  cmd_r;
  logic [TAG_W-1:0]      tag_r;
  logic [SLOT_NUM_W-1:0] slot_num_r;
  logic [TIME_W-1:0]     req_r;
  logic [TIME_W-1:0]     now_r;

  // Table storage. In-use bits reset; the rest is only read for in-use slots,
  // and every slot is fully written when it is claimed.
  logic [SLOTS-1:0]  in_use_r;
  logic [TAG_W-1:0]  tag_mem  [SLOTS];
  logic [TIME_W-1:0] to_mem   [SLOTS];
  logic [TIME_W-1:0] feed_mem [SLOTS];
  logic [TAG_W-1:0]  tag_rd_r;
  logic [TIME_W-1:0] to_rd_r;
  logic [TIME_W-1:0] feed_rd_r;

  // Scan pipeline and accumulators.
  logic [SLOT_W-1:0] scan_addr_r;
  logic [SLOT_W-1:0] eval_idx_r;
  logic              eval_valid_r;
  logic              match_found_r;
  logic [SLOT_W-1:0] match_idx_r;
  logic              free_found_r;
  logic [SLOT_W-1:0] free_idx_r;
  logic [CNT_W-1:0]  count_r;
  logic [SLOT_W-1:0] first_r;

  // Result register.
  logic                out_valid_r;
  status_e             res_status_r;
  logic [SLOT_W-1:0]   res_slot_r;
  logic                res_any_r;
  logic [CNT_W-1:0]    res_count_r;
  logic [SLOT_W-1:0]   res_first_r;

  logic              ev_use;
  logic [TIME_W-1:0] elapsed;
  logic              expired;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_bad;
  logic [TIME_W-1:0] eff_to;
  status_e           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_any;
  logic [CNT_W-1:0]  res_count;
  logic [SLOT_W-1:0] res_first;
  logic              claim;
  logic              to_we;
  logic              feed_we;
  logic [SLOT_W-1:0] wr_idx;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= cmd_e'(in_command);
      tag_r      <= in_name_tag;
      slot_num_r <= in_slot_number;
      req_r      <= in_timeout_seconds;
      now_r      <= in_now_seconds;
    end
  end

  // Scan evaluation on the registered read data.
  assign ev_use  = in_use_r[eval_idx_r];
  assign elapsed = now_r - feed_rd_r;
  assign expired = ev_use && (elapsed > to_rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_addr_r   <= '0;
      eval_idx_r    <= '0;
      eval_valid_r  <= 1'b0;
      match_found_r <= 1'b0;
      match_idx_r   <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      count_r       <= '0;
      first_r       <= '0;
    end else if (cmd.load) begin
      scan_addr_r   <= '0;
      eval_valid_r  <= 1'b0;
      match_found_r <= 1'b0;
      match_idx_r   <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      count_r       <= '0;
      first_r       <= '0;
    end else begin
      eval_valid_r <= cmd.scan_read;
      if (cmd.scan_read) begin
        eval_idx_r  <= scan_addr_r;
        scan_addr_r <= scan_addr_r + SLOT_W'(1);
      end
      if (eval_valid_r) begin
        if (ev_use && (tag_rd_r == tag_r) && !match_found_r) begin
          match_found_r <= 1'b1;
          match_idx_r   <= eval_idx_r;
        end
        if (!ev_use && !free_found_r) begin
          free_found_r <= 1'b1;
          free_idx_r   <= eval_idx_r;
        end
        if (expired) begin
          if (count_r == '0) begin
            first_r <= eval_idx_r;
          end
          count_r <= count_r + CNT_W'(1);
        end
      end
    end
  end

  // Finishing step: decide the result and the table update.
  assign slot_idx = SLOT_W'(slot_num_r);
  assign slot_bad = 32'(slot_num_r) >= 32'(SLOTS);
  assign eff_to   = (req_r < cfg.minimum_timeout) ? cfg.default_timeout : req_r;

  always_comb begin
    res_status = ST_OK;
    res_slot   = '0;
    res_any    = 1'b0;
    res_count  = '0;
    res_first  = '0;
    claim      = 1'b0;
    to_we      = 1'b0;
    feed_we    = 1'b0;
    unique case (cmd_r)
      CMD_REGISTER: begin
        if (match_found_r) begin
          res_slot = match_idx_r;
        end else if (free_found_r) begin
          res_slot = free_idx_r;
          claim    = 1'b1;
          to_we    = 1'b1;
          feed_we  = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_SET_TIMEOUT: begin
        if (slot_bad) begin
          res_status = ST_RANGE;
        end else if (!in_use_r[slot_idx]) begin
          res_status = ST_UNREG;
        end else begin
          to_we = 1'b1;
        end
      end
      CMD_FEED: begin
        if (slot_bad) begin
          res_status = ST_RANGE;
        end else begin
          feed_we = 1'b1;
        end
      end
      CMD_CHECK: begin
        if (cfg.enabled) begin
          res_any   = (count_r != '0);
          res_count = count_r;
          res_first = first_r;
        end
      end
      default: ;
    endcase
  end

  assign wr_idx = claim ? free_idx_r : slot_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cmd.commit && claim) begin
      in_use_r[free_idx_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && claim) begin
      tag_mem[free_idx_r] <= tag_r;
    end
    tag_rd_r <= tag_mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && to_we) begin
      to_mem[wr_idx] <= eff_to;
    end
    to_rd_r <= to_mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && feed_we) begin
      feed_mem[wr_idx] <= now_r;
    end
    feed_rd_r <= feed_mem[scan_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= res_status;
      res_slot_r   <= res_slot;
      res_any_r    <= res_any;
      res_count_r  <= res_count;
      res_first_r  <= res_first;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = res_status_r;
  assign out_result_slot   = RSLOT_W'(res_slot_r);
  assign out_any_expired   = res_any_r;
  assign out_expired_count = ECOUNT_W'(res_count_r);
  assign out_first_expired = RSLOT_W'(res_first_r);

  assign stat.needs_scan = (cmd_r == CMD_REGISTER) || (cmd_r == CMD_CHECK);
  assign stat.last_addr  = (scan_addr_r == SLOT_W'(SLOTS - 1));
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

// ===== rtl/multi_slot_watchdog_table.sv =====
`timescale 1ns / 1ps

// Multi-slot watchdog table with 64 slots.
// Commands arrive as items on in_item (valid/ready): register a 64-bit name
// tag, set a slot's timeout, feed a slot, or check all slots for expiry. Each
// item carries the current time in seconds. Exactly one result item leaves on
// out_item (valid/ready) for every command item, in order.
// Register and check walk the whole table through one read port of the slot
// memories, one slot per cycle; set-timeout and feed skip the walk. The block
// holds one item at a time; a new item is accepted the cycle after the
// previous one has been written into the output register, even while that
// result still waits for the receiver. If the receiver stalls, the finished
// item waits in its final step until the output register frees up, and no
// table update happens before that. Reset clears all in-use bits at once and
// restores the configuration registers (enabled, minimum timeout 1, default
// timeout 60). Configuration is written over the APB-style port at byte
// addresses 0, 4 and 8, and should only change while the block is idle.
module multi_slot_watchdog_table import mswd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  mswd_in_if.sink            in_item,
  mswd_out_if.source         out_item,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t     cfg;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Writes complete in the access phase without wait states.
  assign pready = 1'b1;

  mswd_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The controller sequences one item: dispatch, table walk and drain for register and check, finish.
  mswd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // The datapath owns the slot storage, the scan accumulators and the
  // output register.
  mswd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (dp_cmd),
    .stat               (dp_stat),
    .cfg                (cfg),
    .in_command         (in_item.command),
    .in_name_tag        (in_item.name_tag),
    .in_slot_number     (in_item.slot_number),
    .in_timeout_seconds (in_item.timeout_seconds),
    .in_now_seconds     (in_item.now_seconds),
    .out_valid          (out_item.valid),
    .out_ready          (out_item.ready),
    .out_status         (out_item.status),
    .out_result_slot    (out_item.result_slot),
    .out_any_expired    (out_item.any_expired),
    .out_expired_count  (out_item.expired_count),
    .out_first_expired  (out_item.first_expired)
  );

endmodule

// ===== verif/mswd_checker.sv =====
`timescale 1ns / 1ps

// Watches both item channels and the configuration port, keeps its own copy of
// the watchdog table and compares every result item with the oldest prediction.
module mswd_checker import mswd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  mswd_in_if                 in_mon,
  mswd_out_if                out_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output int                 pending,
  output int                 fail_count
);

  typedef struct {
    status_e               status;
    logic [RSLOT_W-1:0]    result_slot;
    logic                  any_expired;
    logic [ECOUNT_W-1:0]   expired_count;
    logic [RSLOT_W-1:0]    first_expired;
  } wd_result_t;

  logic              cfg_enabled;
  logic [TIME_W-1:0] cfg_min_timeout;
  logic [TIME_W-1:0] cfg_def_timeout;

  logic              slot_used    [SLOTS];
  logic [TAG_W-1:0]  slot_tag     [SLOTS];
  logic [TIME_W-1:0] slot_timeout [SLOTS];
  logic [TIME_W-1:0] slot_fed_at  [SLOTS];

  wd_result_t        results_due [$];

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    fail_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic logic [TIME_W-1:0] granted_timeout(logic [TIME_W-1:0] req);
    return (req < cfg_min_timeout) ? cfg_def_timeout : req;
  endfunction

  // Applies one command to the table copy and returns the result it must give.
  function automatic wd_result_t apply_command(cmd_e cmd, logic [TAG_W-1:0] tag,
                                               logic [SLOT_NUM_W-1:0] slot,
                                               logic [TIME_W-1:0] req,
                                               logic [TIME_W-1:0] now);
    wd_result_t        r;
    int                hit;
    int                count;
    int                first;
    logic [TIME_W-1:0] elapsed;
    r = '{ST_OK, '0, 1'b0, '0, '0};
    hit = -1;
    count = 0;
    first = 0;
    case (cmd)
      CMD_REGISTER: begin
        for (int i = 0; i < SLOTS; i++)
          if (hit < 0 && slot_used[i] && slot_tag[i] == tag) hit = i;
        if (hit < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (hit < 0 && !slot_used[i]) hit = i;
          if (hit >= 0) begin
            slot_used[hit]    = 1'b1;
            slot_tag[hit]     = tag;
            slot_timeout[hit] = granted_timeout(req);
            slot_fed_at[hit]  = now;
          end
        end
        if (hit < 0) r.status = ST_FULL;
        else r.result_slot = hit[RSLOT_W-1:0];
      end
      CMD_SET_TIMEOUT: begin
        if (slot >= SLOTS) r.status = ST_RANGE;
        else if (!slot_used[slot[SLOT_W-1:0]]) r.status = ST_UNREG;
        else slot_timeout[slot[SLOT_W-1:0]] = granted_timeout(req);
      end
      CMD_FEED: begin
        if (slot >= SLOTS) r.status = ST_RANGE;
        else slot_fed_at[slot[SLOT_W-1:0]] = now;
      end
      default: begin
        if (cfg_enabled) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
              elapsed = now - slot_fed_at[i];
              if (elapsed > slot_timeout[i]) begin
                if (count == 0) first = i;
                count++;
              end
            end
          end
          r.any_expired   = (count != 0);
          r.expired_count = count[ECOUNT_W-1:0];
          r.first_expired = first[RSLOT_W-1:0];
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    wd_result_t want;
    if (!rst_n) begin
      cfg_enabled     = 1'b1;
      cfg_min_timeout = 32'd1;
      cfg_def_timeout = 32'd60;
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i]    = 1'b0;
        slot_timeout[i] = 32'd60;
        slot_fed_at[i]  = '0;
      end
      results_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[PADDR_W-1:2]))
          REG_ENABLED:     cfg_enabled = pwdata[0];
          REG_MIN_TIMEOUT: cfg_min_timeout = pwdata;
          REG_DEF_TIMEOUT: cfg_def_timeout = pwdata;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (results_due.size() == 0) begin
          report("result with no command waiting", out_mon.status, '0);
        end else begin
          want = results_due.pop_front();
          if (out_mon.status !== want.status)
            report("status", out_mon.status, want.status);
          if (out_mon.result_slot !== want.result_slot)
            report("result_slot", out_mon.result_slot, want.result_slot);
          if (out_mon.any_expired !== want.any_expired)
            report("any_expired", out_mon.any_expired, want.any_expired);
          if (out_mon.expired_count !== want.expired_count)
            report("expired_count", out_mon.expired_count, want.expired_count);
          if (out_mon.first_expired !== want.first_expired)
            report("first_expired", out_mon.first_expired, want.first_expired);
        end
      end
      if (in_mon.valid && in_mon.ready)
        results_due.push_back(apply_command(cmd_e'(in_mon.command), in_mon.name_tag,
                                            in_mon.slot_number, in_mon.timeout_seconds,
                                            in_mon.now_seconds));
    end
    pending <= results_due.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

// Top of the watchdog table bench. This module only makes stimulus and gives
// the verdict; all prediction and comparison lives in the checker instance.
module tb_top;
  import mswd_pkg::*;

  // The receiver stops taking results for this many cycles once, so that the
  // block holds a finished item in its output register and stalls its input.
  localparam int HOLD_OFF_CYCLES = 500;
  // At the end, wait longer than a register or check item needs, so that any
  // stray result still shows up.
  localparam int DRAIN_CYCLES = SLOTS + 20;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 pending;
  int                 fail_count;

  // calm switches off idling on both sides; hold_off_req asks the receiver
  // for its one long stall.
  logic               calm;
  logic               hold_off_req;
  logic               hold_off_done;

  // Time base for the random items and the tags handed out so far, so that
  // register items often hit a tag the table already holds.
  logic [TIME_W-1:0]  wall_clock;
  logic [TAG_W-1:0]   seen_tags [$];

  mswd_in_if  in_ch ();
  mswd_out_if out_ch ();

  multi_slot_watchdog_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  mswd_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always #10 clk = ~clk;

  // Offers one command item and returns at the clock edge that accepts it.
  // Unless calm is set, a random number of idle cycles comes first.
  task automatic send_cmd(cmd_e cmd, logic [TAG_W-1:0] tag, logic [SLOT_NUM_W-1:0] slot,
                          logic [TIME_W-1:0] tmo, logic [TIME_W-1:0] now);
    while (!calm && $urandom_range(99, 0) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.command         <= cmd;
    in_ch.name_tag        <= tag;
    in_ch.slot_number     <= slot;
    in_ch.timeout_seconds <= tmo;
    in_ch.now_seconds     <= now;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Register write: a setup phase, then an access phase that lasts until
  // pready. The bus then idles before returning, keeping back-to-back writes apart.
  task automatic write_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Stops offering items and waits until every result has come back. The
  // count is sampled on the falling edge, away from the checker's updates.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Random commands. Register items reuse a known tag more often than not, so
  // the table fills slowly; once all slots are taken, new tags see the full
  // table. Most slot numbers are in range, some reach up to 127. Timeouts
  // are mostly small so that checks find a mix of expired and live slots.
  task automatic random_phase(int count);
    cmd_e                  cmd;
    logic [TAG_W-1:0]      tag;
    logic [SLOT_NUM_W-1:0] slot;
    logic [TIME_W-1:0]     tmo;
    int                    pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      cmd = (pick < 25) ? CMD_REGISTER :
            (pick < 45) ? CMD_SET_TIMEOUT :
            (pick < 75) ? CMD_FEED : CMD_CHECK;
      pick = $urandom_range(99, 0);
      if (seen_tags.size() != 0 && pick < 60) begin
        tag = seen_tags[$urandom_range(seen_tags.size() - 1, 0)];
      end else begin
        tag = (pick < 63) ? '0 : (pick < 66) ? '1 : {$urandom, $urandom};
        seen_tags.push_back(tag);
      end
      if ($urandom_range(99, 0) < 85) slot = SLOT_NUM_W'($urandom_range(SLOTS - 1, 0));
      else slot = SLOT_NUM_W'($urandom_range(127, 0));
      case ($urandom_range(5, 0))
        0: tmo = '0;
        1: tmo = '1;
        2: tmo = $urandom;
        default: tmo = $urandom_range(150, 0);
      endcase
      // Time mostly creeps forward and wraps now and then; a rare jump lands
      // anywhere, which makes most registered slots look expired or fresh.
      wall_clock += $urandom_range(40, 0);
      if ($urandom_range(99, 0) < 3) wall_clock = $urandom;
      send_cmd(cmd, tag, slot, tmo, wall_clock);
    end
  endtask

  // Receiver side: takes results at random, or always while calm is set,
  // and stalls once for a long stretch when asked.
  initial begin
    out_ch.ready  = 1'b0;
    hold_off_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99, 0) >= 31);
      end
    end
  end

  // Hard stop in case the block hangs: far beyond the slowest correct run.
  initial begin
    #60_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.command         = CMD_REGISTER;
    in_ch.name_tag        = '0;
    in_ch.slot_number     = '0;
    in_ch.timeout_seconds = '0;
    in_ch.now_seconds     = '0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    calm                  = 1'b0;
    hold_off_req          = 1'b0;
    wall_clock            = 32'hFFFF_F000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, with the reset configuration (minimum 1, default 60).
    // A zero timeout is below the minimum and becomes the default.
    send_cmd(CMD_REGISTER, '0, '0, '0, 32'd100);
    send_cmd(CMD_REGISTER, '1, '1, '1, 32'd100);
    // Registering a tag the table already holds returns its slot and leaves
    // the timeout and the feed time alone.
    send_cmd(CMD_REGISTER, '0, '0, 32'd5, 32'd200);
    send_cmd(CMD_SET_TIMEOUT, '0, 7'd0, 32'd10, 32'd110);
    // Set-timeout on a free slot, and slot numbers just past and far past
    // the end of the table.
    send_cmd(CMD_SET_TIMEOUT, '0, 7'd63, 32'd10, 32'd110);
    send_cmd(CMD_SET_TIMEOUT, '0, 7'd64, 32'd10, 32'd110);
    send_cmd(CMD_FEED, '0, 7'd127, '0, 32'd110);
    // Feeding a free slot is allowed and still records the time.
    send_cmd(CMD_FEED, '0, 7'd5, '0, 32'd7);
    send_cmd(CMD_SET_TIMEOUT, '0, 7'd1, '0, 32'd110);
    // Elapsed equal to the timeout is not expired, one more second is.
    send_cmd(CMD_CHECK, '0, '0, '0, 32'd110);
    send_cmd(CMD_CHECK, '0, '0, '0, 32'd111);
    // Time before the last feed wraps to a huge elapsed time.
    send_cmd(CMD_CHECK, '0, '0, '0, 32'd99);
    send_cmd(CMD_FEED, '0, 7'd0, '0, 32'hFFFF_FFF0);
    send_cmd(CMD_CHECK, '0, '0, '0, 32'd5);
    // A timeout equal to the minimum is kept as it is.
    send_cmd(CMD_REGISTER, 64'h8000_0000_0000_0001, '0, 32'd1, '1);
    send_cmd(CMD_FEED, '0, 7'd2, '0, '0);
    send_cmd(CMD_SET_TIMEOUT, '0, 7'd2, '1, '0);
    wait_idle();

    // With the watchdog disabled a check reports nothing at all.
    write_reg(REG_ENABLED, 32'd0);
    send_cmd(CMD_CHECK, '0, '0, '0, 32'd1000);
    wait_idle();

    // Minimum zero: every requested timeout is kept, even zero.
    write_reg(REG_ENABLED, 32'd1);
    write_reg(REG_MIN_TIMEOUT, 32'd0);
    write_reg(REG_DEF_TIMEOUT, 32'd0);
    random_phase(350);
    wait_idle();

    // Maximum minimum and default: every request becomes all ones.
    write_reg(REG_MIN_TIMEOUT, '1);
    write_reg(REG_DEF_TIMEOUT, '1);
    random_phase(350);
    wait_idle();

    // Disabled, with arbitrary limits.
    write_reg(REG_ENABLED, 32'd0);
    write_reg(REG_MIN_TIMEOUT, $urandom);
    write_reg(REG_DEF_TIMEOUT, $urandom);
    random_phase(350);
    wait_idle();

    // Default below the minimum; the first part runs with no idling at all.
    write_reg(REG_ENABLED, 32'd1);
    write_reg(REG_MIN_TIMEOUT, 32'd100);
    write_reg(REG_DEF_TIMEOUT, 32'd20);
    calm = 1'b1;
    random_phase(150);
    calm = 1'b0;
    random_phase(200);
    wait_idle();

    // Back to the reset values. Partway through, the receiver stalls for a
    // long time while items keep being offered.
    write_reg(REG_MIN_TIMEOUT, 32'd1);
    write_reg(REG_DEF_TIMEOUT, 32'd60);
    random_phase(100);
    hold_off_req = 1'b1;
    random_phase(250);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mswd_pkg.sv
rtl/mswd_if.sv
rtl/mswd_regs.sv
rtl/mswd_ctrl.sv
rtl/mswd_dp.sv
rtl/multi_slot_watchdog_table.sv
verif/mswd_checker.sv
verif/tb_top.sv
